// ===== src/sidx_pkg.sv =====
// ----------------------------------------------------------------------------
// sidx_pkg
// Shared constants and types for the sorted key index block.
// ----------------------------------------------------------------------------
package sidx_pkg;

    localparam int unsigned MAX_RECORDS_DEF = 1024;
    localparam int unsigned KEY_W           = 64;
    localparam int unsigned REC_IDX_W       = 10;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_WR,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_DONE
    } t_state;

endpackage

// ===== src/sidx_if.sv =====
// ----------------------------------------------------------------------------
// sidx_in_if / sidx_out_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface sidx_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [63:0] key;
    logic               last;

    modport source (output valid, op, key, last, input ready);
    modport sink   (input valid, op, key, last, output ready);
endinterface

interface sidx_out_if;
    logic       valid;
    logic       ready;
    logic       found;
    logic [9:0] record_index;

    modport source (output valid, found, record_index, input ready);
    modport sink   (input valid, found, record_index, output ready);
endinterface

// ===== src/sorted_id_index_lookup.sv =====
// ----------------------------------------------------------------------------
// sorted_id_index_lookup
// Sorted key index: loads keys into a sorted table, answers binary searches.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                 | meaning
//  --------+-----+-------------------------+-----------------------------------
//  i_in    | in  | op, key, last           | load a key or look one up
//  o_out   | out | found, record_index     | one result per lookup
//
//  A load inserts its key at its sorted place right away: the table walks
//  down from the end, reading each stored key greater than the new one and
//  moving it up a slot, and writes the new key where the walk stops, at a
//  key not greater or at slot 0; a load past capacity is dropped.
//  A lookup is a binary search of up to ceil(log2(n+1)) probes for n entries
//  (11 for 1024); each probe reads the table through its single read port
//  and compares, and a hit ends the search at the probe that matches.
//  Reset is synchronous; it clears the state, count, built flag and valid only.
//  A finished result holds in the output register while the sink stalls;
//  the next request is still taken, and a later lookup waits in its final
//  state until the output register is free.
//
module sorted_id_index_lookup
    import sidx_pkg::*;
#(
    parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sidx_in_if.sink      i_in,
    sidx_out_if.source   o_out
);

    localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
    localparam int unsigned EW = KEY_W + AW;
    localparam int unsigned XW = (AW > REC_IDX_W) ? AW : REC_IDX_W;
    localparam logic [CW-1:0] CAP = CW'(MAX_RECORDS);

    // Table entry: sign-flipped key (unsigned order = signed order) and index
    logic [EW-1:0] mem [MAX_RECORDS];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic [EW-1:0] w_wr_data;
    logic          w_we;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_built, n_built;
    logic [CW-1:0] r_ptr, n_ptr;       // insertion slot
    logic [CW-1:0] r_low, n_low;
    logic [CW-1:0] r_high, n_high;
    logic [CW-1:0] r_mid, n_mid;
    logic [KEY_W-1:0] r_key, n_key;    // flipped key of the transaction
    logic [AW-1:0] r_idx, n_idx;       // arrival index of a load
    logic          r_hit, n_hit;
    logic [AW-1:0] r_hit_idx, n_hit_idx;
    logic          r_ov, n_ov;
    logic          r_found, n_found;
    logic [REC_IDX_W-1:0] r_ridx, n_ridx;

    logic [CW:0]   w_sum;
    logic [CW-1:0] w_mid;
    logic [KEY_W-1:0] w_rd_key;
    logic [AW-1:0] w_rd_idx;
    logic          w_in_acc;
    logic          w_out_free;
    logic [CW-1:0] w_eff_count;
    logic [XW-1:0] w_idx_ext;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_ov || o_out.ready;
    assign w_sum       = {1'b0, r_low} + {1'b0, r_high} - (CW+1)'(1);
    assign w_mid       = w_sum[CW:1];
    assign w_rd_key    = r_rd[EW-1:AW];
    assign w_rd_idx    = r_rd[AW-1:0];
    // a load after a built table starts a new set
    assign w_eff_count = r_built ? '0 : r_count;
    assign w_idx_ext   = XW'(r_hit_idx);

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_ov;
    assign o_out.found        = r_found;
    assign o_out.record_index = r_ridx;

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.op == OP_LOAD) begin
                        if (w_eff_count < CAP) n_state = ST_INS_RD;
                    end else if (r_built && r_count != '0) begin
                        n_state = ST_SRCH_RD;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_INS_RD: begin
                n_state = (r_ptr == '0) ? ST_IDLE : ST_INS_WR;
            end
            ST_INS_WR: begin
                n_state = (w_rd_key > r_key) ? ST_INS_RD : ST_IDLE;
            end
            ST_SRCH_RD: begin
                n_state = (r_low < r_high) ? ST_SRCH_CMP : ST_DONE;
            end
            ST_SRCH_CMP: begin
                n_state = (w_rd_key == r_key) ? ST_DONE : ST_SRCH_RD;
            end
            ST_DONE: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---- datapath and memory control ----
    always_comb begin
        n_count   = r_count;
        n_built   = r_built;
        n_ptr     = r_ptr;
        n_low     = r_low;
        n_high    = r_high;
        n_mid     = r_mid;
        n_key     = r_key;
        n_idx     = r_idx;
        n_hit     = r_hit;
        n_hit_idx = r_hit_idx;
        n_ov      = r_ov && !o_out.ready;
        n_found   = r_found;
        n_ridx    = r_ridx;
        w_rd_addr = '0;
        w_wr_addr = r_ptr[AW-1:0];
        w_wr_data = {r_key, r_idx};
        w_we      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_key = {~i_in.key[KEY_W-1], i_in.key[KEY_W-2:0]};
                    n_hit = 1'b0;
                    n_hit_idx = '0;
                    if (i_in.op == OP_LOAD) begin
                        n_count = w_eff_count;
                        n_built = i_in.last;
                        if (w_eff_count < CAP) begin
                            n_count = w_eff_count + CW'(1);
                            n_ptr   = w_eff_count;
                            n_idx   = w_eff_count[AW-1:0];
                        end
                    end else begin
                        n_low  = '0;
                        n_high = r_count;
                    end
                end
            end
            ST_INS_RD: begin
                w_rd_addr = r_ptr[AW-1:0] - AW'(1);
                // slot 0 reached: drop the new entry in place
                if (r_ptr == '0) w_we = 1'b1;
            end
            ST_INS_WR: begin
                w_we = 1'b1;
                if (w_rd_key > r_key) begin
                    w_wr_data = r_rd;
                    n_ptr     = r_ptr - CW'(1);
                end
            end
            ST_SRCH_RD: begin
                w_rd_addr = w_mid[AW-1:0];
                n_mid     = w_mid;
            end
            ST_SRCH_CMP: begin
                if (w_rd_key == r_key) begin
                    n_hit     = 1'b1;
                    n_hit_idx = w_rd_idx;
                end else if (w_rd_key < r_key) begin
                    n_low = r_mid + CW'(1);
                end else begin
                    n_high = r_mid;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_ov    = 1'b1;
                    n_found = r_hit;
                    n_ridx  = r_hit ? w_idx_ext[REC_IDX_W-1:0] : '0;
                end
            end
            default: ;
        endcase
    end

    // ---- table memory ----
    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wr_addr] <= w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[w_rd_addr];
    end

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_built <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_built <= n_built;
            r_ov    <= n_ov;
        end
    end

    // ---- payload registers ----
    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_low     <= n_low;
        r_high    <= n_high;
        r_mid     <= n_mid;
        r_key     <= n_key;
        r_idx     <= n_idx;
        r_hit     <= n_hit;
        r_hit_idx <= n_hit_idx;
        r_found   <= n_found;
        r_ridx    <= n_ridx;
    end

endmodule

// ===== verif/sorted_id_index_lookup_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_id_index_lookup_test
// Loads key sets of varied size and order, then looks keys up at random and
// checks every answer against a stable-sorted copy searched by halving.
// ----------------------------------------------------------------------------
module sorted_id_index_lookup_test;
    import sidx_pkg::*;

    localparam int unsigned CAP = MAX_RECORDS_DEF;

    logic i_clk;
    logic i_rst_n;

    sidx_in_if  req_ch ();
    sidx_out_if res_ch ();

    sorted_id_index_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source)
    );

    typedef struct packed {
        logic       found;
        logic [9:0] record_index;
    } t_answer;

    // Shadow of the table: keys in sorted order with their arrival index.
    logic signed [63:0] shadow_keys [CAP];
    logic [9:0]         shadow_idx  [CAP];
    int unsigned        shadow_count;
    bit                 shadow_built;
    // Keys of the current set, used to pick lookups that hit.
    logic signed [63:0] loaded_keys [$];

    t_answer     answer_q [$];
    int unsigned error_count;
    bit          idle_enable;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("** sorted_id_index_lookup: FAILED **");
        $finish;
    end

    // Stable insertion: shift up every stored key greater than the new one, so equal keys keep arrival order.
    function automatic void shadow_load(logic signed [63:0] k, bit lst);
        int unsigned j;
        if (shadow_built) begin
            shadow_built = 1'b0;
            shadow_count = 0;
            loaded_keys.delete();
        end
        if (shadow_count < CAP) begin
            j = shadow_count;
            while (j > 0 && shadow_keys[j-1] > k) begin
                shadow_keys[j] = shadow_keys[j-1];
                shadow_idx[j]  = shadow_idx[j-1];
                j--;
            end
            shadow_keys[j] = k;
            shadow_idx[j]  = 10'(shadow_count);
            shadow_count++;
            loaded_keys.push_back(k);
        end
        if (lst) shadow_built = 1'b1;
    endfunction

    function automatic t_answer shadow_search(logic signed [63:0] k);
        t_answer     a;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        a = '0;
        lo = 0;
        hi = shadow_count;
        if (!shadow_built) return a;
        while (lo < hi) begin
            mid = (lo + hi - 1) / 2;
            if (shadow_keys[mid] == k) begin
                a.found = 1'b1;
                a.record_index = shadow_idx[mid];
                return a;
            end else if (shadow_keys[mid] < k) begin
                lo = mid + 1;
            end else begin
                hi = mid;
            end
        end
        return a;
    endfunction

    function automatic bit roll_idle();
        return idle_enable && ($urandom_range(99) < 37);
    endfunction

    // Drive one transaction; predict once it is accepted.
    task automatic send_item(logic op, logic signed [63:0] k, logic lst);
        @(negedge i_clk);
        while (roll_idle()) @(negedge i_clk);
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.key   <= k;
        req_ch.last  <= lst;
        do @(posedge i_clk); while (!req_ch.ready);
        if (op == OP_LOAD) shadow_load(k, lst);
        else               answer_q.push_back(shadow_search(k));
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (answer_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic signed [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // Lookup key: mostly a loaded key, sometimes a neighbor or noise.
    function automatic logic signed [63:0] pick_key();
        logic signed [63:0] k;
        if (loaded_keys.size() == 0 || $urandom_range(9) < 2) return rand_key();
        k = loaded_keys[$urandom_range(loaded_keys.size() - 1)];
        case ($urandom_range(5))
            0: k = k + 1;
            1: k = k - 1;
            default: ;
        endcase
        return k;
    endfunction

    // Result side: stall at random, compare each transaction with the oldest answer.
    always @(negedge i_clk) begin
        res_ch.ready <= !roll_idle();
    end

    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result found=%0b index=%0d", $time,
                         res_ch.found, res_ch.record_index);
                error_count++;
            end else begin
                exp_a = answer_q.pop_front();
                if (res_ch.found !== exp_a.found) begin
                    $display("%0t: found expected %0b actual %0b", $time,
                             exp_a.found, res_ch.found);
                    error_count++;
                end
                if (res_ch.record_index !== exp_a.record_index) begin
                    $display("%0t: record_index expected %0d actual %0d", $time,
                             exp_a.record_index, res_ch.record_index);
                    error_count++;
                end
            end
        end
    end

    // A lookup before any load and one on an open set, then an extremes set with duplicates.
    task automatic test_directed();
        send_item(OP_LOOKUP, 64'sd0, 1'b0);
        send_item(OP_LOAD, 64'sd5, 1'b0);
        send_item(OP_LOOKUP, 64'sd5, 1'b1);          // set still open: not found
        send_item(OP_LOAD, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(OP_LOAD, 64'h8000_0000_0000_0000, 1'b0);
        send_item(OP_LOAD, 64'sd5, 1'b0);
        send_item(OP_LOAD, -64'sd1, 1'b0);
        send_item(OP_LOAD, 64'sd5, 1'b1);
        send_item(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(OP_LOOKUP, 64'h8000_0000_0000_0000, 1'b1);
        send_item(OP_LOOKUP, 64'sd5, 1'b0);
        send_item(OP_LOOKUP, -64'sd1, 1'b0);
        send_item(OP_LOOKUP, 64'sd4, 1'b0);
        send_item(OP_LOOKUP, 64'sd0, 1'b0);
        // One-entry set replaces the old table.
        send_item(OP_LOAD, -64'sd7, 1'b1);
        send_item(OP_LOOKUP, -64'sd7, 1'b0);
        send_item(OP_LOOKUP, 64'sd5, 1'b0);
        // Hold the sender until every answer is in.
        drain();
    endtask

    // Random sets: small (1 to 12 keys), random or duplicate-heavy keys.
    task automatic test_random_sets();
        int unsigned size;
        int unsigned n;
        bit dup_heavy;
        for (int s = 0; s < 10; s++) begin
            size = $urandom_range(1, 12);
            dup_heavy = 1'($urandom_range(1));
            for (int i = 0; i < size; i++)
                send_item(OP_LOAD, dup_heavy ? 64'($signed($urandom_range(7)) - 3)
                                             : rand_key(), i == size - 1);
            n = $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
                send_item(OP_LOOKUP, pick_key(), 1'($urandom_range(1)));
            if ($urandom_range(3) == 0) send_item(OP_LOAD, rand_key(), 1'b0);  // open set
            if (s == 3) idle_enable = 1'b0;
            if (s == 7) idle_enable = 1'b1;
        end
        drain();
    endtask

    // Fill past capacity; the two overflow keys must be dropped but last still closes.
    task automatic test_capacity();
        for (int i = 0; i < CAP + 2; i++)
            send_item(OP_LOAD, 64'($signed(i)) * 3 - 1500, i == CAP + 1);
        for (int i = 0; i < 30; i++) send_item(OP_LOOKUP, pick_key(), 1'b0);
        send_item(OP_LOOKUP, 64'(CAP) * 3 - 1500, 1'b0);
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_LOAD;
        req_ch.key = '0;
        req_ch.last = 1'b0;
        res_ch.ready = 1'b0;
        error_count = 0;
        shadow_count = 0;
        shadow_built = 1'b0;
        idle_enable = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_sets();
        test_capacity();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && answer_q.size() == 0) begin
            $display("** sorted_id_index_lookup: PASSED **");
        end else begin
            $display("** sorted_id_index_lookup: FAILED **");
        end
        $finish;
    end
endmodule
